[rtl/nnis_pkg.sv]
`default_nettype none

package nnis_pkg;

	// Sizes settled by the item and register fields.
	localparam int COORD_BITS = 8;
	localparam int REG_BITS   = 9;
	localparam int PIX_BITS   = 32;
	localparam int PROD_BITS  = COORD_BITS + REG_BITS;
	localparam int STEP_BITS  = $clog2(REG_BITS);
	localparam int IDX_BITS   = 2;

	// Store geometry defaults.
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_PIXEL_BITS = 32;

	// Configuration register indexes.
	localparam logic [IDX_BITS-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_DST_HEIGHT = 2'd3;

	localparam logic [REG_BITS-1:0] REG_RESET_SIZE = 9'd64;

	// Item function codes.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_FETCH = 1'b1;

	typedef struct packed {
		logic                  func;
		logic [COORD_BITS-1:0] x_coord;
		logic [COORD_BITS-1:0] y_coord;
		logic [PIX_BITS-1:0]   pixel_in;
	} in_item_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] pixel_out;
		logic                out_of_range;
	} out_item_t;

endpackage

`default_nettype wire

[rtl/nnis_ram.sv]
`default_nettype none

module nnis_ram #(
	parameter int WIDTH     = 32,
	parameter int DEPTH     = 65536,
	parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [ADDR_BITS-1:0] raddr,
	output logic      [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/nnis_div.sv]
`default_nettype none

module nnis_div
	import nnis_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [PROD_BITS-1:0] num,
	input  wire logic [REG_BITS-1:0]  den,
	output logic                      done,
	output logic      [REG_BITS-1:0]  quot
);

	logic [REG_BITS-1:0]  rem_q;
	logic [REG_BITS-1:0]  num_q;
	logic [REG_BITS-1:0]  den_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [REG_BITS+1:0]  diff;
	logic                 borrow;

	// The caller guarantees a quotient below 2**REG_BITS, so the high part of the
	// numerator is already smaller than the divisor and only REG_BITS steps remain.
	assign diff   = {1'b0, rem_q, num_q[REG_BITS-1]} - {2'b00, den_q};
	assign borrow = diff[REG_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_BITS'(REG_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= REG_BITS'(num[PROD_BITS-1:REG_BITS]);
			num_q <= num[REG_BITS-1:0];
			den_q <= den;
		end else if (busy_q) begin
			if (!borrow) begin
				rem_q <= diff[REG_BITS-1:0];
			end else begin
				rem_q <= {rem_q[REG_BITS-2:0], num_q[REG_BITS-1]};
			end
			num_q <= {num_q[REG_BITS-2:0], ~borrow};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

`default_nettype wire

[rtl/nearest_neighbor_image_scaler.sv]
`default_nettype none

// Nearest-neighbor scaler over a source image held in an internal pixel RAM.
// A load item writes one pixel and gives no result; loads outside
// the configured source size are dropped. A fetch item returns the
// source pixel at floor(x*src_width/dst_width), floor(y*src_height/dst_height),
// or zero with out_of_range set when (x,y) lies outside the destination size.
// A fetch works through each axis in turn with a multiply state and a shared
// 9-step restoring divider, then does one RAM read. An out-of-range fetch
// skips these and goes straight to the result. No new item is taken while a fetch
// is being worked on, but one is taken while a finished result waits on stall.
// The RAM is not cleared at reset; read only pixels that were loaded. The user must
// write configuration registers only while the block is idle; it does not enforce this.
module nearest_neighbor_image_scaler
	import nnis_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire in_item_t            in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output out_item_t                out_item,
	input  wire logic                cfg_we,
	input  wire logic [IDX_BITS-1:0] cfg_index,
	input  wire logic [REG_BITS-1:0] cfg_data
);

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int AFW         = ADDR_BITS + 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0]            state_q;
	logic [REG_BITS-1:0]   sw_q, sh_q, dw_q, dh_q;
	logic [COORD_BITS-1:0] x_q, y_q;
	logic [REG_BITS-1:0]   sx_q, sy_q;
	logic                  axis_q;
	logic                  oor_q;
	logic                  map_ok_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  in_accept;
	logic                  load_ok;
	logic                  fetch_oor;
	logic [COORD_BITS-1:0] mul_a;
	logic [REG_BITS-1:0]   mul_b;
	logic [PROD_BITS-1:0]  product;
	logic [REG_BITS-1:0]   div_den;
	logic                  div_start;
	logic                  div_done;
	logic [REG_BITS-1:0]   div_quot;
	logic [REG_BITS-1:0]   addr_x, addr_y;
	logic [AFW-1:0]        addr_full;
	logic [ADDR_BITS-1:0]  ram_addr;
	logic                  ram_we;
	logic                  ram_re;
	logic [PIXEL_BITS-1:0] ram_rdata;
	logic                  result_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign load_ok = ({1'b0, in_item.x_coord} < sw_q) && ({1'b0, in_item.y_coord} < sh_q)
		&& (int'(in_item.x_coord) < MAX_WIDTH) && (int'(in_item.y_coord) < MAX_HEIGHT);
	assign fetch_oor = ({1'b0, in_item.x_coord} >= dw_q) || ({1'b0, in_item.y_coord} >= dh_q);

	// One multiplier and one divider serve both axes in turn.
	assign mul_a     = axis_q ? y_q : x_q;
	assign mul_b     = axis_q ? sh_q : sw_q;
	assign div_den   = axis_q ? dh_q : dw_q;
	assign product   = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
	assign div_start = (state_q == ST_MUL);

	nnis_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (product),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Loads address the RAM from the item, fetches from the mapped coordinate.
	assign addr_x    = (state_q == ST_IDLE) ? {1'b0, in_item.x_coord} : sx_q;
	assign addr_y    = (state_q == ST_IDLE) ? {1'b0, in_item.y_coord} : sy_q;
	assign addr_full = AFW'(addr_y) * AFW'(MAX_WIDTH) + AFW'(addr_x);
	assign ram_addr  = addr_full[ADDR_BITS-1:0];
	assign ram_we    = in_accept && (in_item.func == FUNC_LOAD) && load_ok;
	assign ram_re    = (state_q == ST_READ);

	nnis_ram #(
		.WIDTH     (PIXEL_BITS),
		.DEPTH     (STORE_DEPTH),
		.ADDR_BITS (ADDR_BITS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (in_item.pixel_in[PIXEL_BITS-1:0]),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	assign result_load = (state_q == ST_RESULT) && !(out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= REG_RESET_SIZE;
			sh_q <= REG_RESET_SIZE;
			dw_q <= REG_RESET_SIZE;
			dh_q <= REG_RESET_SIZE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH:  sw_q <= cfg_data;
				REG_SRC_HEIGHT: sh_q <= cfg_data;
				REG_DST_WIDTH:  dw_q <= cfg_data;
				REG_DST_HEIGHT: dh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (in_item.func == FUNC_FETCH)) begin
						axis_q  <= 1'b0;
						state_q <= fetch_oor ? ST_RESULT : ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						axis_q  <= 1'b1;
						state_q <= axis_q ? ST_READ : ST_MUL;
					end
				end
				ST_READ: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (result_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q      <= in_item.x_coord;
			y_q      <= in_item.y_coord;
			oor_q    <= fetch_oor;
			map_ok_q <= 1'b0;
		end
		if (div_done) begin
			if (axis_q) begin
				sy_q <= div_quot;
			end else begin
				sx_q <= div_quot;
			end
		end
		// A mapped coordinate past the source size or the store reads as zero.
		if (state_q == ST_READ) begin
			map_ok_q <= (sx_q < sw_q) && (sy_q < sh_q)
				&& (int'(sx_q) < MAX_WIDTH) && (int'(sy_q) < MAX_HEIGHT);
		end
		if (result_load) begin
			out_q.pixel_out    <= map_ok_q ? PIX_BITS'(ram_rdata) : '0;
			out_q.out_of_range <= oor_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("pixel store written while a fetch is in progress");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_oor_zero_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.out_of_range) |-> (out_item.pixel_out == '0))
		else $error("out-of-range result carries a nonzero pixel");

	a_result_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RESULT) && !(out_valid && out_stall)) |=> out_valid)
		else $error("finished fetch did not reach the output register");

endmodule

`default_nettype wire

[sim/pixel_fetch_checker.sv]
`timescale 1ns / 1ps

module pixel_fetch_checker
	import nnis_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire in_item_t            in_item,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire out_item_t           out_item,
	input  wire logic                cfg_we,
	input  wire logic [IDX_BITS-1:0] cfg_index,
	input  wire logic [REG_BITS-1:0] cfg_data,
	output int                       mismatches,
	output int                       pending
);

	localparam int STORE_W      = DEF_MAX_WIDTH;
	localparam int STORE_H      = DEF_MAX_HEIGHT;
	localparam int REPORT_LIMIT = 10;

	bit [PIX_BITS-1:0] source_image [STORE_W*STORE_H];
	int src_w = REG_RESET_SIZE;
	int src_h = REG_RESET_SIZE;
	int dst_w = REG_RESET_SIZE;
	int dst_h = REG_RESET_SIZE;
	out_item_t expected_pixels [$];
	out_item_t want;

	// Nearest source pixel for destination (x, y) under the current geometry.
	function automatic out_item_t scaled_pixel(input int x, input int y);
		out_item_t r;
		int sx;
		int sy;
		r = '0;
		if (x >= dst_w || y >= dst_h) begin
			r.out_of_range = 1'b1;
			return r;
		end
		sx = x * src_w / dst_w;
		sy = y * src_h / dst_h;
		// A mapped pixel outside the source or the store reads as zero.
		if (sx < src_w && sy < src_h && sx < STORE_W && sy < STORE_H)
			r.pixel_out = source_image[sy*STORE_W + sx];
		return r;
	endfunction

	task automatic flag(input string what, input out_item_t exp_item, input out_item_t got);
		if (mismatches < REPORT_LIMIT)
			$display("%0t: %s: expected pixel %08h out_of_range %0b, got pixel %08h out_of_range %0b",
				$time, what, exp_item.pixel_out, exp_item.out_of_range,
				got.pixel_out, got.out_of_range);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w = REG_RESET_SIZE;
			src_h = REG_RESET_SIZE;
			dst_w = REG_RESET_SIZE;
			dst_h = REG_RESET_SIZE;
			expected_pixels.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_WIDTH:  src_w = cfg_data;
					REG_SRC_HEIGHT: src_h = cfg_data;
					REG_DST_WIDTH:  dst_w = cfg_data;
					REG_DST_HEIGHT: dst_h = cfg_data;
					default: ;
				endcase
			end
			// Results are checked before this edge's item is predicted; no fetch
			// answers in the cycle it is taken.
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					flag("result with no fetch waiting", '0, out_item);
				end else begin
					want = expected_pixels.pop_front();
					if (out_item.pixel_out !== want.pixel_out ||
						out_item.out_of_range !== want.out_of_range)
						flag("fetch result differs", want, out_item);
				end
			end
			if (in_valid && !in_stall) begin
				if (in_item.func == FUNC_LOAD) begin
					if (in_item.x_coord < src_w && in_item.y_coord < src_h)
						source_image[{in_item.y_coord, in_item.x_coord}] = in_item.pixel_in;
				end else begin
					expected_pixels.push_back(scaled_pixel(in_item.x_coord, in_item.y_coord));
				end
			end
			pending = expected_pixels.size();
		end
	end

endmodule

[sim/nearest_neighbor_image_scaler_tb.sv]
`timescale 1ns / 1ps

module nearest_neighbor_image_scaler_tb;
	import nnis_pkg::*;

	localparam int RANDOM_ITEMS   = 1800;
	localparam int CALM_ITEMS     = 250;
	localparam int HOLD_AFTER     = 300;
	localparam int LONG_HOLD      = 400;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int STORE_W        = DEF_MAX_WIDTH;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic [IDX_BITS-1:0] cfg_index;
	logic [REG_BITS-1:0] cfg_data;
	int mismatches;
	int pending;

	// Geometry as last written, and which source pixels hold a loaded value.
	int src_w = REG_RESET_SIZE;
	int src_h = REG_RESET_SIZE;
	int dst_w = REG_RESET_SIZE;
	int dst_h = REG_RESET_SIZE;
	bit loaded [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
	bit calm = 1'b0;
	bit hold_now = 1'b0;
	int idle_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	nearest_neighbor_image_scaler uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pixel_fetch_checker fetch_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: random stall bursts, one long hold-off, none near the end.
	initial begin : result_side
		bit hold_served;
		bit stall_now;
		int span;
		hold_served = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_now && !hold_served) begin
				hold_served = 1'b1;
				stall_now = 1'b1;
				span = LONG_HOLD;
			end else if (calm) begin
				stall_now = 1'b0;
				span = 1;
			end else begin
				stall_now = ($urandom_range(0, 2) == 0);
				span = $urandom_range(1, 11);
			end
			out_stall <= stall_now;
			repeat (span) @(posedge clk);
		end
	end

	task automatic offer(input in_item_t it);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_load(input int x, input int y, input logic [PIX_BITS-1:0] pix);
		in_item_t it;
		it.func = FUNC_LOAD;
		it.x_coord = x[COORD_BITS-1:0];
		it.y_coord = y[COORD_BITS-1:0];
		it.pixel_in = pix;
		if (x < src_w && y < src_h)
			loaded[y*STORE_W + x] = 1'b1;
		offer(it);
	endtask

	task automatic send_fetch(input int x, input int y);
		in_item_t it;
		it.func = FUNC_FETCH;
		it.x_coord = x[COORD_BITS-1:0];
		it.y_coord = y[COORD_BITS-1:0];
		it.pixel_in = $urandom();
		offer(it);
	endtask

	// Wait until every fetch has answered and any load has landed.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[REG_BITS-1:0];
		@(posedge clk);
	endtask

	task automatic set_geometry(input int sw, input int sh, input int dw, input int dh);
		settle();
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		cfg_we <= 1'b0;
		src_w = sw;
		src_h = sh;
		dst_w = dw;
		dst_h = dh;
	endtask

	function automatic int extreme_size();
		if ($urandom_range(0, 2) == 0)
			return 1;
		return $urandom_range(0, 1) ? 256 : $urandom_range(1, 256);
	endfunction

	initial begin : stimulus
		int sent;
		int phase_len;
		int kind;
		int x;
		int y;
		int sx;
		int sy;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SRC_WIDTH;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry, 64 by 64 both ways: corners, and loads past the source.
		send_load(0, 0, 32'h0000_0000);
		send_load(63, 63, 32'hFFFF_FFFF);
		send_load(64, 5, 32'hA5A5_A5A5);
		send_load(5, 64, 32'h5A5A_5A5A);
		send_load(255, 255, 32'hDEAD_BEEF);
		send_fetch(0, 0);
		send_fetch(63, 63);
		send_fetch(64, 0);
		send_fetch(0, 255);
		send_fetch(255, 255);

		// Full-size image, mapped one to one.
		set_geometry(256, 256, 256, 256);
		send_load(255, 255, 32'h8000_0001);
		send_load(255, 0, 32'h7FFF_FFFE);
		send_load(0, 255, 32'h1234_5678);
		send_fetch(255, 255);
		send_fetch(255, 0);
		send_fetch(0, 255);

		// Strongest downscale and upscale.
		set_geometry(256, 256, 1, 1);
		send_fetch(0, 0);
		send_fetch(1, 0);
		set_geometry(1, 1, 256, 256);
		send_fetch(255, 255);

		// Sizes outside the usual range: the mapped pixel lies beyond the source
		// or the store, or the destination has zero width.
		set_geometry(300, 0, 256, 1);
		send_load(10, 0, 32'h0F0F_0F0F);
		send_fetch(255, 0);
		set_geometry(0, 256, 2, 2);
		send_fetch(1, 1);
		set_geometry(511, 511, 0, 3);
		send_fetch(0, 0);
		set_geometry(511, 256, 256, 256);
		send_fetch(255, 0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind < 6)
				set_geometry($urandom_range(1, 16), $urandom_range(1, 16),
					$urandom_range(1, 32), $urandom_range(1, 32));
			else if (kind < 8)
				set_geometry(extreme_size(), extreme_size(), extreme_size(), extreme_size());
			else
				set_geometry($urandom_range(1, 256), $urandom_range(1, 256),
					$urandom_range(1, 256), $urandom_range(1, 256));
			phase_len = $urandom_range(60, 200);
			for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
				if (sent >= HOLD_AFTER)
					hold_now = 1'b1;
				if ($urandom_range(0, 4) < 2) begin
					if ($urandom_range(0, 6) == 0) begin
						x = $urandom_range(0, 255);
						y = $urandom_range(0, 255);
					end else begin
						x = $urandom_range(0, src_w - 1);
						y = $urandom_range(0, src_h - 1);
					end
					send_load(x, y, $urandom());
					if (x < src_w && y < src_h)
						sent++;
				end else begin
					if ($urandom_range(0, 9) == 0) begin
						x = $urandom_range(0, 255);
						y = $urandom_range(0, 255);
					end else begin
						x = $urandom_range(0, dst_w > 256 ? 255 : dst_w - 1);
						y = $urandom_range(0, dst_h > 256 ? 255 : dst_h - 1);
					end
					sx = 0;
					sy = 0;
					if (x < dst_w && y < dst_h) begin
						sx = x * src_w / dst_w;
						sy = y * src_h / dst_h;
					end
					// Never read a source pixel that was not loaded: load it instead.
					if (x < dst_w && y < dst_h && !loaded[sy*STORE_W + sx])
						send_load(sx, sy, $urandom());
					else
						send_fetch(x, y);
					sent++;
				end
			end
		end

		settle();
		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
rtl/nnis_pkg.sv
rtl/nnis_ram.sv
rtl/nnis_div.sv
rtl/nearest_neighbor_image_scaler.sv
sim/pixel_fetch_checker.sv
sim/nearest_neighbor_image_scaler_tb.sv
